// File: design/lkvt_pkg.sv
// Shared types and codes of the linear key/value table.
// Used by linear_key_value_table_top and the testbench; depends on nothing else.
package lkvt_pkg;

  typedef enum logic [2:0] {
    K_PUT     = 3'd0,
    K_GET     = 3'd1,
    K_REMOVE  = 3'd2,
    K_REPLACE = 3'd3,
    K_HAS_KEY = 3'd4,
    K_HAS_VAL = 3'd5,
    K_CLEAR   = 3'd6,
    K_PEEK    = 3'd7
  } kind_t;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_MISS  = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    kind_t              kind;
    logic signed [31:0] key;
    logic [31:0]        value;
    logic [5:0]         index;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [5:0]  entry_count;
  } rsp_t;

endpackage

// File: design/linear_key_value_table_top.sv
// Top level of the linear key/value table: sequencer, key and value memories.
// Depends on lkvt_pkg.
//
// Channel   Direction  Handshake               Payload
// request   in         start high, busy low    req (lkvt_pkg::req_t)
// response  out        done strobe, one cycle  rsp (lkvt_pkg::rsp_t)
//
// A scan reads one slot per cycle from the memories and compares it in the following
// cycle, until a match or the end of the fill count ends the search.
// Remove on a hit then fetches the last entry in S_LAST and moves it into the freed slot.
// Peek is answered from S_PEEK; clear stops the scan at once and empties the table.
// Reset is synchronous and empties the table; memory contents are kept.
// The receiver cannot stall: each result is shown for one cycle with done high.
module linear_key_value_table_top #(
  parameter int CAPACITY = 32
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  lkvt_pkg::req_t  req,
  output logic            done,
  output lkvt_pkg::rsp_t  rsp
);
  import lkvt_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_PEEK = 4'b0100,
    S_LAST = 4'b1000
  } state_t;

  state_t          state, state_next;
  req_t            cur, cur_next;
  logic [CW-1:0]   fill, fill_next;
  logic [CW-1:0]   ptr, ptr_next;
  logic            cmp_vld, cmp_vld_next;
  logic [AW-1:0]   cmp_addr, cmp_addr_next;
  logic [AW-1:0]   slot, slot_next;
  logic [31:0]     hold, hold_next;
  logic            done_next;
  rsp_t            rsp_next;

  logic [31:0]     key_mem [CAPACITY];
  logic [31:0]     val_mem [CAPACITY];
  logic [31:0]     rd_key, rd_val;
  logic [AW-1:0]   rd_addr, wr_addr;
  logic [31:0]     wr_key, wr_val;
  logic            key_we, val_we;

  logic            accept, match_cond, match, exhausted, scan_stop;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  always_comb begin
    case (cur.kind)
      K_HAS_KEY: match_cond = (rd_key != 32'd0) && (rd_key == $unsigned(cur.key));
      K_HAS_VAL: match_cond = (rd_key != 32'd0) && (rd_val == cur.value);
      default:   match_cond = (rd_key == $unsigned(cur.key));
    endcase
  end

  assign match     = cmp_vld && match_cond;
  assign exhausted = !cmp_vld && (ptr >= fill);
  assign scan_stop = (cur.kind == K_CLEAR) ||
                     ((cur.kind == K_HAS_VAL) && (cur.value == 32'd0));

  always_comb begin
    state_next    = state;
    cur_next      = cur;
    fill_next     = fill;
    ptr_next      = ptr;
    cmp_vld_next  = 1'b0;
    cmp_addr_next = cmp_addr;
    slot_next     = slot;
    hold_next     = hold;
    done_next     = 1'b0;
    rsp_next      = rsp;
    rd_addr       = ptr[AW-1:0];
    wr_addr       = cmp_addr;
    wr_key        = $unsigned(cur.key);
    wr_val        = cur.value;
    key_we        = 1'b0;
    val_we        = 1'b0;

    case (state)
      S_IDLE: begin
        rd_addr = AW'(req.index);
        if (accept) begin
          cur_next = req;
          ptr_next = '0;
          state_next = (req.kind == K_PEEK) ? S_PEEK : S_SCAN;
        end
      end
      S_SCAN: begin
        rsp_next.hit      = 1'b0;
        rsp_next.data_out = 32'd0;
        rsp_next.status   = ST_MISS;
        if (scan_stop) begin
          done_next = 1'b1;
          state_next = S_IDLE;
          if (cur.kind == K_CLEAR) begin
            fill_next = '0;
            rsp_next.status = ST_DONE;
          end
        end else if (match) begin
          rsp_next.hit    = 1'b1;
          rsp_next.status = ST_MATCH;
          case (cur.kind)
            K_PUT, K_REPLACE: begin
              rsp_next.data_out = rd_val;
              val_we = 1'b1;
              done_next = 1'b1;
              state_next = S_IDLE;
            end
            K_GET: begin
              rsp_next.data_out = rd_val;
              done_next = 1'b1;
              state_next = S_IDLE;
            end
            K_REMOVE: begin
              rd_addr = AW'(fill - 1'b1);
              slot_next = cmp_addr;
              hold_next = rd_val;
              state_next = S_LAST;
            end
            default: begin
              done_next = 1'b1;
              state_next = S_IDLE;
            end
          endcase
        end else if (exhausted) begin
          done_next = 1'b1;
          state_next = S_IDLE;
          if (cur.kind == K_PUT) begin
            if (32'(fill) >= 32'(CAPACITY)) begin
              rsp_next.data_out = cur.value;
              rsp_next.status   = ST_FULL;
            end else begin
              wr_addr = AW'(fill);
              key_we = 1'b1;
              val_we = 1'b1;
              fill_next = fill + 1'b1;
              rsp_next.status = ST_DONE;
            end
          end
        end else if (ptr < fill) begin
          cmp_vld_next  = 1'b1;
          cmp_addr_next = ptr[AW-1:0];
          ptr_next      = ptr + 1'b1;
        end
      end
      S_PEEK: begin
        done_next = 1'b1;
        state_next = S_IDLE;
        if (32'(cur.index) < 32'(fill)) begin
          rsp_next.hit      = 1'b1;
          rsp_next.data_out = rd_val;
          rsp_next.status   = ST_MATCH;
        end else begin
          rsp_next.hit      = 1'b0;
          rsp_next.data_out = 32'd0;
          rsp_next.status   = ST_MISS;
        end
      end
      S_LAST: begin
        wr_addr = slot;
        wr_key  = rd_key;
        wr_val  = rd_val;
        key_we  = 1'b1;
        val_we  = 1'b1;
        fill_next = fill - 1'b1;
        rsp_next.hit      = 1'b1;
        rsp_next.data_out = hold;
        rsp_next.status   = ST_MATCH;
        done_next = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    rsp_next.entry_count = 6'(fill_next);
  end

  always_ff @(posedge clk) begin
    if (key_we) key_mem[wr_addr] <= wr_key;
    if (val_we) val_mem[wr_addr] <= wr_val;
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      fill    <= '0;
      ptr     <= '0;
      cmp_vld <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      fill    <= fill_next;
      ptr     <= ptr_next;
      cmp_vld <= cmp_vld_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    cmp_addr <= cmp_addr_next;
    slot     <= slot_next;
    hold     <= hold_next;
    rsp      <= rsp_next;
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("Result strobe while the sequencer is still busy.");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("An accepted item did not make the block busy.");

  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(CAPACITY))
    else $error("Fill count beyond capacity.");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (done && (rsp.status == ST_FULL)) |-> (32'(fill) == 32'(CAPACITY)))
    else $error("Full status reported while the table has room.");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_LAST) |-> (fill != '0))
    else $error("Remove write-back with an empty table.");

endmodule

// File: test/testbench.sv
// Self-checking testbench for linear_key_value_table_top: directed rows, then random requests.
// Expected responses come from the row itself for typed rows, else from a shadow copy of the table kept in this file.
// Depends on lkvt_pkg and linear_key_value_table_top.
`timescale 1ns / 1ps

module testbench;
  import lkvt_pkg::*;

  localparam int CAP = 32;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1400;

  typedef struct {
    req_t rq;
    bit   typed;
    rsp_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  req_t req = '0;
  logic busy;
  logic done;
  rsp_t rsp;

  logic [31:0] shadow_key [CAP];
  logic [31:0] shadow_val [CAP];
  int          shadow_fill = 0;
  logic [31:0] key_pool [48];
  int          pool_size = 6;
  rsp_t        rsp_due [$];
  rsp_t        want_rsp;
  int          err_count = 0;
  int          stall_cycles = 0;
  bit          gaps_on = 1'b1;

  linear_key_value_table_top #(.CAPACITY(CAP)) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req(req),
    .done(done),
    .rsp(rsp)
  );

  always #5 clk = ~clk;

  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int slot;
    int last;
    o = '0;
    o.status = ST_MISS;
    slot = -1;
    for (int i = 0; i < shadow_fill; i++) begin
      if (slot < 0 && shadow_key[i] == r.key) slot = i;
    end
    case (r.kind)
      K_PUT: begin
        if (slot >= 0) begin
          o.hit = 1'b1;
          o.data_out = shadow_val[slot];
          shadow_val[slot] = r.value;
          o.status = ST_MATCH;
        end else if (shadow_fill >= CAP) begin
          o.data_out = r.value;
          o.status = ST_FULL;
        end else begin
          shadow_key[shadow_fill] = r.key;
          shadow_val[shadow_fill] = r.value;
          shadow_fill++;
          o.status = ST_DONE;
        end
      end
      K_GET, K_REPLACE: begin
        if (slot >= 0) begin
          o.hit = 1'b1;
          o.data_out = shadow_val[slot];
          if (r.kind == K_REPLACE) shadow_val[slot] = r.value;
          o.status = ST_MATCH;
        end
      end
      K_REMOVE: begin
        if (slot >= 0) begin
          o.hit = 1'b1;
          o.data_out = shadow_val[slot];
          last = shadow_fill - 1;
          shadow_key[slot] = shadow_key[last];
          shadow_val[slot] = shadow_val[last];
          shadow_fill--;
          o.status = ST_MATCH;
        end
      end
      K_HAS_KEY: begin
        for (int i = 0; i < shadow_fill; i++) begin
          if (shadow_key[i] != 32'd0 && shadow_key[i] == r.key) begin
            o.hit = 1'b1;
            o.status = ST_MATCH;
          end
        end
      end
      K_HAS_VAL: begin
        if (r.value != 32'd0) begin
          for (int i = 0; i < shadow_fill; i++) begin
            if (shadow_key[i] != 32'd0 && shadow_val[i] == r.value) begin
              o.hit = 1'b1;
              o.status = ST_MATCH;
            end
          end
        end
      end
      K_CLEAR: begin
        shadow_fill = 0;
        o.status = ST_DONE;
      end
      default: begin
        if (int'(r.index) < shadow_fill) begin
          o.hit = 1'b1;
          o.data_out = shadow_val[r.index];
          o.status = ST_MATCH;
        end
      end
    endcase
    o.entry_count = shadow_fill[5:0];
    return o;
  endfunction

  function automatic row_t dir_row(kind_t k, logic [31:0] key, logic [31:0] val,
                                   logic [5:0] idx, int typed, int h = 0,
                                   logic [31:0] d = 32'd0, logic [1:0] s = ST_DONE,
                                   int c = 0);
    row_t rw;
    rw.rq.kind = k;
    rw.rq.key = key;
    rw.rq.value = val;
    rw.rq.index = idx;
    rw.typed = typed[0];
    rw.want.hit = h[0];
    rw.want.data_out = d;
    rw.want.status = s;
    rw.want.entry_count = c[5:0];
    return rw;
  endfunction

  function automatic logic [31:0] pick_key(bit for_put);
    int roll;
    roll = $urandom_range(0, 99);
    if (shadow_fill > 0 && roll < (for_put ? 20 : 50))
      return shadow_key[$urandom_range(0, shadow_fill - 1)];
    if (roll < 92) return key_pool[$urandom_range(0, pool_size - 1)];
    return $urandom;
  endfunction

  task automatic issue(req_t r, bit typed, rsp_t want);
    rsp_t predicted;
    if (gaps_on && $urandom_range(0, 99) < 7) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    start <= 1'b1;
    req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(r);
    rsp_due.push_back(typed ? want : predicted);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (rsp_due.size() == 0) begin
        $display("%0t: result with nothing outstanding: %p", $time, rsp);
        err_count++;
      end else begin
        want_rsp = rsp_due.pop_front();
        check_field("hit", 32'(want_rsp.hit), 32'(rsp.hit));
        check_field("data_out", want_rsp.data_out, rsp.data_out);
        check_field("status", 32'(want_rsp.status), 32'(rsp.status));
        check_field("entry_count", 32'(want_rsp.entry_count), 32'(rsp.entry_count));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    row_t  rows [$];
    req_t  rq;
    kind_t kd;
    int    sent;
    int    roll;
    int    w;
    rows.push_back(dir_row(K_PEEK, 32'd0, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 0));
    rows.push_back(dir_row(K_GET, 32'h8000_0000, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 0));
    rows.push_back(dir_row(K_REMOVE, 32'd5, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 0));
    rows.push_back(dir_row(K_REPLACE, 32'd7, 32'hDEAD_BEEF, 6'd0, 1, 0, 0, ST_MISS, 0));
    rows.push_back(dir_row(K_HAS_KEY, 32'd0, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 0));
    rows.push_back(dir_row(K_HAS_VAL, 32'd0, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 0));
    rows.push_back(dir_row(K_PUT, 32'h8000_0000, 32'hFFFF_FFFF, 6'd63, 1, 0, 0, ST_DONE, 1));
    rows.push_back(dir_row(K_PUT, 32'h7FFF_FFFF, 32'd0, 6'd0, 1, 0, 0, ST_DONE, 2));
    rows.push_back(dir_row(K_PUT, 32'd0, 32'h1234_5678, 6'd0, 1, 0, 0, ST_DONE, 3));
    rows.push_back(dir_row(K_PUT, 32'h7FFF_FFFF, 32'hA5A5_A5A5, 6'd0, 1, 1, 0, ST_MATCH, 3));
    rows.push_back(dir_row(K_GET, 32'h8000_0000, 32'd0, 6'd0, 1, 1, 32'hFFFF_FFFF,
                           ST_MATCH, 3));
    rows.push_back(dir_row(K_HAS_KEY, 32'd0, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 3));
    rows.push_back(dir_row(K_HAS_VAL, 32'd0, 32'h1234_5678, 6'd0, 1, 0, 0, ST_MISS, 3));
    rows.push_back(dir_row(K_HAS_VAL, 32'd0, 32'hA5A5_A5A5, 6'd0, 1, 1, 0, ST_MATCH, 3));
    rows.push_back(dir_row(K_HAS_KEY, 32'h7FFF_FFFF, 32'd0, 6'd0, 1, 1, 0, ST_MATCH, 3));
    rows.push_back(dir_row(K_REPLACE, 32'd0, 32'hFFFF_FFFF, 6'd0, 0));
    rows.push_back(dir_row(K_PEEK, 32'd0, 32'd0, 6'd2, 0));
    rows.push_back(dir_row(K_PEEK, 32'd0, 32'd0, 6'd63, 1, 0, 0, ST_MISS, 3));
    rows.push_back(dir_row(K_REMOVE, 32'h8000_0000, 32'd0, 6'd0, 0));
    rows.push_back(dir_row(K_PEEK, 32'd0, 32'd0, 6'd0, 0));
    rows.push_back(dir_row(K_HAS_KEY, 32'hFFFF_FFFF, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 2));
    rows.push_back(dir_row(K_CLEAR, 32'd0, 32'd0, 6'd0, 1, 0, 0, ST_DONE, 0));
    rows.push_back(dir_row(K_PEEK, 32'd0, 32'd0, 6'd0, 1, 0, 0, ST_MISS, 0));

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (rows[i]) issue(rows[i].rq, rows[i].typed, rows[i].want);

    // Fill phases lean on puts over a wide key pool so the table reaches full;
    // remove phases drain it again.
    sent = 0;
    for (int ph = 0; sent < RANDOM_ITEMS; ph++) begin
      case ($urandom_range(0, 2))
        0: pool_size = 6;
        1: pool_size = 20;
        default: pool_size = 48;
      endcase
      if (ph % 3 == 0) pool_size = 48;
      for (int i = 0; i < 48; i++) key_pool[i] = $urandom;
      if ($urandom_range(0, 1)) key_pool[0] = 32'd0;
      if ($urandom_range(0, 1)) key_pool[1] = 32'h8000_0000;
      if ($urandom_range(0, 1)) key_pool[2] = 32'h7FFF_FFFF;
      gaps_on = !(ph >= 4 && ph <= 6);
      for (int n = 0; n < 100; n++) begin
        roll = $urandom_range(0, 99);
        w = $urandom_range(0, 99);
        if (ph % 3 == 0 && roll < 80) kd = K_PUT;
        else if (ph % 3 == 2 && roll < 40) kd = K_REMOVE;
        else if (w < 30) kd = K_PUT;
        else if (w < 45) kd = K_GET;
        else if (w < 57) kd = K_REMOVE;
        else if (w < 67) kd = K_REPLACE;
        else if (w < 77) kd = K_HAS_KEY;
        else if (w < 87) kd = K_HAS_VAL;
        else if (w < 89) kd = K_CLEAR;
        else kd = K_PEEK;
        rq.kind = kd;
        rq.key = pick_key(kd == K_PUT);
        roll = $urandom_range(0, 99);
        rq.value = (roll < 10) ? 32'd0 : (roll < 20) ? 32'hFFFF_FFFF : $urandom;
        rq.index = 6'($urandom_range(0, 63));
        if (kd == K_HAS_VAL && shadow_fill > 0 && $urandom_range(0, 1))
          rq.value = shadow_val[$urandom_range(0, shadow_fill - 1)];
        if (kd == K_PEEK && shadow_fill > 0 && $urandom_range(0, 99) < 60)
          rq.index = 6'($urandom_range(0, shadow_fill - 1));
        issue(rq, 1'b0, '0);
        sent++;
      end
      if (ph % 4 == 1) begin
        start <= 1'b0;
        while (rsp_due.size() != 0) @(posedge clk);
      end
    end

    start <= 1'b0;
    while (rsp_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (err_count == 0 && rsp_due.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
